FILE: hdl/tss_pkg.sv
package tss_pkg;

    // Fixed field widths
    localparam int SAMPLE_BITS = 12;
    localparam int STAMP_IN_BITS = 16;
    localparam int SPEED_BITS = 16;
    localparam int LEVEL_BITS = 10;
    localparam int REF_BITS = 14;
    localparam int MODE_BITS = 2;
    localparam int CFG_DATA_BITS = 14;
    localparam int CFG_INDEX_BITS = 3;

    // Level limits
    localparam logic [LEVEL_BITS-1:0] LEVEL_MAX = 10'd1000;
    localparam logic [LEVEL_BITS-1:0] LEVEL_RESET = 10'd400;

    // Frequency is a 1 MHz tick count divided into one second
    localparam int DIV_BITS = 20;
    localparam logic [DIV_BITS-1:0] TICKS_PER_SEC = 20'd1000000;
    localparam logic [SPEED_BITS-1:0] SPEED_SAT = 16'hFFFF;

    // Step cadence counters
    localparam logic [2:0] MOD5_WRAP = 3'd4;
    localparam logic [2:0] MOD5_HIT = 3'd4;
    localparam logic [5:0] MOD40_WRAP = 6'd39;
    localparam logic [5:0] MOD40_HIT = 6'd36;

    // Brake: a sample below this clears the period start stamp
    localparam logic [SAMPLE_BITS-1:0] BRAKE_CLEAR_MV = 12'd5;

    // Configuration reset values
    localparam logic [REF_BITS-1:0] REF_SPEED_RESET = 14'd400;
    localparam logic [SAMPLE_BITS-1:0] HIGH_THR_RESET = 12'd2800;
    localparam logic [SAMPLE_BITS-1:0] LOW_THR_RESET = 12'd100;
    localparam logic [REF_BITS-1:0] COARSE_RESET = 14'd260;
    localparam logic [REF_BITS-1:0] FINE_RESET = 14'd40;

    typedef enum logic [MODE_BITS-1:0] {
        MODE_RUN = 2'd0,
        MODE_DYN_BRAKE = 2'd1,
        MODE_ACT_BRAKE = 2'd2,
        MODE_SPARE = 2'd3
    } brake_mode_t;

    typedef enum logic [CFG_INDEX_BITS-1:0] {
        CFG_REF_SPEED = 3'd0,
        CFG_HIGH_THR = 3'd1,
        CFG_LOW_THR = 3'd2,
        CFG_COARSE = 3'd3,
        CFG_FINE = 3'd4,
        CFG_BRAKE = 3'd5
    } cfg_index_t;

    typedef struct packed {
        logic [REF_BITS-1:0] ref_speed;
        logic [SAMPLE_BITS-1:0] high_thr;
        logic [SAMPLE_BITS-1:0] low_thr;
        logic [REF_BITS-1:0] coarse_band;
        logic [REF_BITS-1:0] fine_band;
        logic [MODE_BITS-1:0] brake_mode;
    } cfg_t;

    typedef struct packed {
        logic done;
        logic [DIV_BITS-1:0] quotient;
    } div_stat_t;

    typedef enum logic [0:0] {
        ST_IDLE = 1'b0,
        ST_DIV = 1'b1
    } state_t;

endpackage

FILE: hdl/tss_cfg.sv
module tss_cfg (
    input  logic clk,
    input  logic rst_n,
    input  logic cfg_we,
    input  logic [tss_pkg::CFG_INDEX_BITS-1:0] cfg_index,
    input  logic [tss_pkg::CFG_DATA_BITS-1:0] cfg_wdata,
    output tss_pkg::cfg_t cfg
);

    tss_pkg::cfg_t cfg_reg;
    tss_pkg::cfg_t cfg_next;

    // Register file write decode; unknown indexes are dropped
    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_we)
        begin
            case (cfg_index)
                tss_pkg::CFG_REF_SPEED: cfg_next.ref_speed = cfg_wdata;
                tss_pkg::CFG_HIGH_THR:
                    cfg_next.high_thr = cfg_wdata[tss_pkg::SAMPLE_BITS-1:0];
                tss_pkg::CFG_LOW_THR:
                    cfg_next.low_thr = cfg_wdata[tss_pkg::SAMPLE_BITS-1:0];
                tss_pkg::CFG_COARSE: cfg_next.coarse_band = cfg_wdata;
                tss_pkg::CFG_FINE: cfg_next.fine_band = cfg_wdata;
                tss_pkg::CFG_BRAKE:
                    cfg_next.brake_mode = cfg_wdata[tss_pkg::MODE_BITS-1:0];
                default: cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.ref_speed <= tss_pkg::REF_SPEED_RESET;
            cfg_reg.high_thr <= tss_pkg::HIGH_THR_RESET;
            cfg_reg.low_thr <= tss_pkg::LOW_THR_RESET;
            cfg_reg.coarse_band <= tss_pkg::COARSE_RESET;
            cfg_reg.fine_band <= tss_pkg::FINE_RESET;
            cfg_reg.brake_mode <= tss_pkg::MODE_DYN_BRAKE;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

FILE: hdl/tss_divider.sv
module tss_divider #(
    parameter int DIVISOR_BITS = 16
) (
    input  logic clk,
    input  logic rst_n,
    input  logic start,
    input  logic [DIVISOR_BITS-1:0] divisor,
    output tss_pkg::div_stat_t stat
);

    localparam int CNT_BITS = $clog2(tss_pkg::DIV_BITS + 1);

    logic busy_reg, busy_next;
    logic done_reg, done_next;
    logic [CNT_BITS-1:0] cnt_reg, cnt_next;
    logic [tss_pkg::DIV_BITS-1:0] dvd_reg, dvd_next;
    logic [tss_pkg::DIV_BITS-1:0] quo_reg, quo_next;
    logic [DIVISOR_BITS-1:0] rem_reg, rem_next;
    logic [DIVISOR_BITS-1:0] dvs_reg, dvs_next;
    logic [DIVISOR_BITS:0] trial;
    logic fits;

    // One restoring step per cycle: shift in a dividend bit, try a subtract
    assign trial = {rem_reg, dvd_reg[tss_pkg::DIV_BITS-1]};
    assign fits = trial >= {1'b0, dvs_reg};

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next = cnt_reg;
        dvd_next = dvd_reg;
        quo_next = quo_reg;
        rem_next = rem_reg;
        dvs_next = dvs_reg;
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next = CNT_BITS'(tss_pkg::DIV_BITS - 1);
            dvd_next = tss_pkg::TICKS_PER_SEC;
            quo_next = '0;
            rem_next = '0;
            dvs_next = divisor;
        end
        else if (busy_reg)
        begin
            dvd_next = {dvd_reg[tss_pkg::DIV_BITS-2:0], 1'b0};
            quo_next = {quo_reg[tss_pkg::DIV_BITS-2:0], fits};
            if (fits)
            begin
                rem_next = DIVISOR_BITS'(trial - {1'b0, dvs_reg});
            end
            else
            begin
                rem_next = trial[DIVISOR_BITS-1:0];
            end
            if (cnt_reg == '0)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
            else
            begin
                cnt_next = cnt_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        dvd_reg <= dvd_next;
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        dvs_reg <= dvs_next;
    end

    assign stat.done = done_reg;
    assign stat.quotient = quo_reg;

endmodule

FILE: hdl/tachometer_speed_stepper_core.sv
// Tachometer speed stepper core.
// Input channel (in_valid/in_ready) takes one beat per sensor sample: sample_mv
// and the free-running microsecond timestamp_us. Output channel
// (out_valid/out_ready) returns exactly one beat per input beat: PWM compare
// value, drive level, measured speed, an update flag and the two brake pins.
// Configuration is written through cfg_we/cfg_index/cfg_wdata; the user must
// do so only while idle, as the block does not enforce it. Most beats produce a
// registered result in the cycle after acceptance. A beat that closes the speed
// recompute period runs the 20-step restoring divider (one quotient bit per
// cycle), answered when it reports done. Ordinary samples pass at one beat per
// cycle while the receiver keeps up; no beat is taken while the divider runs.
// The block takes a new beat only when the output register is empty or is
// being emptied in the same cycle, so a stalled receiver holds off the input.
// Reset clears the detector, period counters and measured speed, returns the
// drive level to 400 and loads the register defaults (dynamic brake mode).
module tachometer_speed_stepper_core #(
    parameter int STAMP_BITS = 16,
    parameter int UPDATE_INTERVAL = 60
) (
    input  logic clk,
    input  logic rst_n,
    input  logic in_valid,
    output logic in_ready,
    input  logic [11:0] sample_mv,
    input  logic [15:0] timestamp_us,
    output logic out_valid,
    input  logic out_ready,
    output logic [9:0] compare_value,
    output logic [9:0] drive_level,
    output logic [15:0] speed_rpm,
    output logic speed_updated,
    output logic dynamic_brake_pin,
    output logic active_brake_pin,
    input  logic cfg_we,
    input  logic [2:0] cfg_index,
    input  logic [13:0] cfg_wdata
);

    localparam int CNT_BITS = $clog2(UPDATE_INTERVAL + 1);

    tss_pkg::cfg_t cfg;
    tss_pkg::div_stat_t div_stat;
    tss_pkg::state_t state_reg, state_next;

    logic armed_reg, armed_next;
    logic [tss_pkg::SAMPLE_BITS-1:0] prev_reg, prev_next;
    logic second_reg, second_next;
    logic [STAMP_BITS-1:0] start_reg, start_next;
    logic [CNT_BITS-1:0] count_reg, count_next;
    logic [2:0] mod5_reg, mod5_next;
    logic [5:0] mod40_reg, mod40_next;
    logic [tss_pkg::SPEED_BITS-1:0] speed_reg, speed_next;
    logic [tss_pkg::LEVEL_BITS-1:0] level_reg, level_next;

    logic out_valid_reg, out_valid_next;
    logic [tss_pkg::LEVEL_BITS-1:0] cmp_reg, cmp_next;
    logic upd_reg, upd_next;
    logic dyn_reg, dyn_next;
    logic act_reg, act_next;

    logic accept;
    logic div_start;
    logic [31:0] stamp_wide;
    logic [STAMP_BITS-1:0] stamp;
    logic [STAMP_BITS-1:0] period;
    logic [tss_pkg::SPEED_BITS-1:0] ref_ext;
    logic [tss_pkg::SPEED_BITS-1:0] err;
    logic [tss_pkg::SPEED_BITS-1:0] freq;
    logic [tss_pkg::DIV_BITS-1:0] spd_x15;
    logic armed_now;
    logic pulse;
    logic step_en;

    tss_cfg u_cfg (
        .clk(clk),
        .rst_n(rst_n),
        .cfg_we(cfg_we),
        .cfg_index(cfg_index),
        .cfg_wdata(cfg_wdata),
        .cfg(cfg)
    );

    tss_divider #(
        .DIVISOR_BITS(STAMP_BITS)
    ) u_div (
        .clk(clk),
        .rst_n(rst_n),
        .start(div_start),
        .divisor(period),
        .stat(div_stat)
    );

    // Timestamp narrowed to the configured timer width
    assign stamp_wide = 32'(timestamp_us);
    assign stamp = stamp_wide[STAMP_BITS-1:0];
    assign period = stamp - start_reg;

    assign in_ready = (state_reg == tss_pkg::ST_IDLE) && (!out_valid_reg || out_ready);
    assign accept = in_valid && in_ready;

    // Speed error magnitude
    assign ref_ext = tss_pkg::SPEED_BITS'(cfg.ref_speed);
    assign err = (ref_ext > speed_reg) ? ref_ext - speed_reg : speed_reg - ref_ext;

    // Detector: arming is tested before the pulse check on the same sample
    assign armed_now = armed_reg || (sample_mv > cfg.high_thr);
    assign pulse = armed_now && (sample_mv < cfg.low_thr) && (prev_reg < cfg.low_thr);

    // Frequency saturation and freq * 15 as a shift and subtract
    assign freq = (div_stat.quotient > tss_pkg::DIV_BITS'(tss_pkg::SPEED_SAT))
                ? tss_pkg::SPEED_SAT : div_stat.quotient[tss_pkg::SPEED_BITS-1:0];
    assign spd_x15 = {freq, 4'b0000} - tss_pkg::DIV_BITS'(freq);

    always_comb
    begin
        state_next = state_reg;
        armed_next = armed_reg;
        prev_next = prev_reg;
        second_next = second_reg;
        start_next = start_reg;
        count_next = count_reg;
        mod5_next = mod5_reg;
        mod40_next = mod40_reg;
        speed_next = speed_reg;
        level_next = level_reg;
        out_valid_next = out_valid_reg;
        cmp_next = cmp_reg;
        upd_next = upd_reg;
        dyn_next = dyn_reg;
        act_next = act_reg;
        div_start = 1'b0;
        step_en = 1'b0;

        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            tss_pkg::ST_IDLE:
            begin
                if (accept)
                begin
                    upd_next = 1'b0;
                    dyn_next = 1'b0;
                    act_next = 1'b0;
                    out_valid_next = 1'b1;
                    if (cfg.brake_mode == tss_pkg::MODE_RUN)
                    begin
                        armed_next = pulse ? 1'b0 : armed_now;
                        prev_next = sample_mv;
                        if (pulse && !second_reg)
                        begin
                            // Opening edge of a period
                            start_next = stamp;
                            second_next = 1'b1;
                        end
                        else if (pulse)
                        begin
                            second_next = 1'b0;
                            if (count_reg < CNT_BITS'(UPDATE_INTERVAL))
                            begin
                                count_next = count_reg + 1'b1;
                                mod5_next = (mod5_reg == tss_pkg::MOD5_WRAP)
                                          ? 3'd0 : mod5_reg + 3'd1;
                                mod40_next = (mod40_reg == tss_pkg::MOD40_WRAP)
                                           ? 6'd0 : mod40_reg + 6'd1;
                                if (err > tss_pkg::SPEED_BITS'(cfg.coarse_band))
                                begin
                                    step_en = 1'b1;
                                end
                                else if (err > tss_pkg::SPEED_BITS'(cfg.fine_band))
                                begin
                                    step_en = (mod5_next == tss_pkg::MOD5_HIT);
                                end
                                else
                                begin
                                    step_en = (mod40_next == tss_pkg::MOD40_HIT);
                                end
                            end
                            else
                            begin
                                // Recompute period: result waits for the divider
                                count_next = '0;
                                mod5_next = '0;
                                mod40_next = '0;
                                div_start = 1'b1;
                                out_valid_next = 1'b0;
                                state_next = tss_pkg::ST_DIV;
                            end
                        end
                        // Step one count toward the reference, held to 0..1000
                        if (step_en)
                        begin
                            if (speed_reg <= ref_ext)
                            begin
                                if (level_reg < tss_pkg::LEVEL_MAX)
                                begin
                                    level_next = level_reg + 1'b1;
                                end
                            end
                            else if (level_reg != '0)
                            begin
                                level_next = level_reg - 1'b1;
                            end
                        end
                        cmp_next = tss_pkg::LEVEL_MAX - level_next;
                    end
                    else
                    begin
                        // Braking: detector frozen, level holds
                        act_next = (cfg.brake_mode == tss_pkg::MODE_ACT_BRAKE);
                        dyn_next = (cfg.brake_mode != tss_pkg::MODE_ACT_BRAKE);
                        if (sample_mv < tss_pkg::BRAKE_CLEAR_MV)
                        begin
                            start_next = '0;
                        end
                        cmp_next = tss_pkg::LEVEL_MAX;
                    end
                end
            end
            tss_pkg::ST_DIV:
            begin
                if (div_stat.done)
                begin
                    speed_next = (spd_x15 > tss_pkg::DIV_BITS'(tss_pkg::SPEED_SAT))
                               ? tss_pkg::SPEED_SAT : spd_x15[tss_pkg::SPEED_BITS-1:0];
                    upd_next = 1'b1;
                    cmp_next = tss_pkg::LEVEL_MAX - level_reg;
                    out_valid_next = 1'b1;
                    state_next = tss_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = tss_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= tss_pkg::ST_IDLE;
            armed_reg <= 1'b0;
            prev_reg <= '0;
            second_reg <= 1'b0;
            start_reg <= '0;
            count_reg <= '0;
            mod5_reg <= '0;
            mod40_reg <= '0;
            speed_reg <= '0;
            level_reg <= tss_pkg::LEVEL_RESET;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            armed_reg <= armed_next;
            prev_reg <= prev_next;
            second_reg <= second_next;
            start_reg <= start_next;
            count_reg <= count_next;
            mod5_reg <= mod5_next;
            mod40_reg <= mod40_next;
            speed_reg <= speed_next;
            level_reg <= level_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Result payload
    always_ff @(posedge clk)
    begin
        cmp_reg <= cmp_next;
        upd_reg <= upd_next;
        dyn_reg <= dyn_next;
        act_reg <= act_next;
    end

    assign out_valid = out_valid_reg;
    assign compare_value = cmp_reg;
    assign drive_level = level_reg;
    assign speed_rpm = speed_reg;
    assign speed_updated = upd_reg;
    assign dynamic_brake_pin = dyn_reg;
    assign active_brake_pin = act_reg;

endmodule

FILE: sim/tss_checker.sv
`timescale 1ns / 100ps

// Watches both beat channels and the register port, predicts every result
// beat of the tachometer core and compares it with what comes out.
module tss_checker #(
    parameter int STAMP_BITS = 16,
    parameter int UPDATE_INTERVAL = 60
) (
    input  logic clk,
    input  logic rst_n,
    input  logic in_valid,
    input  logic in_ready,
    input  logic [11:0] sample_mv,
    input  logic [15:0] timestamp_us,
    input  logic out_valid,
    input  logic out_ready,
    input  logic [9:0] compare_value,
    input  logic [9:0] drive_level,
    input  logic [15:0] speed_rpm,
    input  logic speed_updated,
    input  logic dynamic_brake_pin,
    input  logic active_brake_pin,
    input  logic cfg_we,
    input  logic [2:0] cfg_index,
    input  logic [13:0] cfg_wdata,
    output int mismatches,
    output int pending
);

    typedef struct packed {
        logic [9:0] compare;
        logic [9:0] level;
        logic [15:0] rpm;
        logic updated;
        logic dyn;
        logic act;
    } drive_result_t;

    // Register copy
    logic [13:0] ref_rpm;
    logic [11:0] arm_mv;
    logic [11:0] pulse_mv;
    logic [13:0] coarse_rpm;
    logic [13:0] fine_rpm;
    tss_pkg::brake_mode_t mode;

    // Tachometer state copy
    logic is_armed;
    logic [11:0] last_mv;
    logic closing_edge;
    logic [STAMP_BITS-1:0] open_stamp;
    logic [5:0] periods;
    logic [15:0] speed;
    logic [9:0] level;

    drive_result_t due_drive_q[$];
    drive_result_t got;
    drive_result_t want;

    // One level step toward the target, clamped to 0..1000
    function automatic void step_level();
        if (speed <= {2'b00, ref_rpm})
        begin
            if (level < tss_pkg::LEVEL_MAX)
                level = level + 10'd1;
        end
        else if (level != 10'd0)
        begin
            level = level - 10'd1;
        end
    endfunction

    // Second pulse of a pair: step the level or, on the interval wrap, remeasure
    function automatic logic close_period(input logic [STAMP_BITS-1:0] stamp);
        logic [STAMP_BITS-1:0] span;
        int unsigned freq;
        int unsigned rpm;
        int unsigned err;
        int unsigned target;
        int unsigned now;
        span = stamp - open_stamp;
        freq = 65535;
        if (span != '0)
        begin
            freq = 1000000 / 32'(span);
            if (freq > 65535)
                freq = 65535;
        end
        if (int'(periods) < UPDATE_INTERVAL)
        begin
            periods = periods + 6'd1;
            target = ref_rpm;
            now = speed;
            err = (target > now) ? target - now : now - target;
            if (err > coarse_rpm)
                step_level();
            else if (err > fine_rpm)
            begin
                if (periods % 5 == 4)
                    step_level();
            end
            else if (periods % 40 == 36)
            begin
                step_level();
            end
            return 1'b0;
        end
        periods = '0;
        rpm = freq * 15;
        speed = (rpm > 65535) ? 16'hFFFF : rpm[15:0];
        return 1'b1;
    endfunction

    // Advance the state by one sample beat and build its result
    function automatic drive_result_t next_drive_result(input logic [11:0] sample,
                                                        input logic [15:0] stamp_in);
        drive_result_t r;
        logic [STAMP_BITS-1:0] stamp;
        r = '0;
        stamp = STAMP_BITS'(stamp_in);
        if (mode == tss_pkg::MODE_RUN)
        begin
            // arming is tested first, so one sample may arm and pulse
            if (!is_armed && sample > arm_mv)
                is_armed = 1'b1;
            if (is_armed && sample < pulse_mv && last_mv < pulse_mv)
            begin
                is_armed = 1'b0;
                if (!closing_edge)
                begin
                    open_stamp = stamp;
                    closing_edge = 1'b1;
                end
                else
                begin
                    closing_edge = 1'b0;
                    r.updated = close_period(stamp);
                end
            end
            last_mv = sample;
            r.compare = tss_pkg::LEVEL_MAX - level;
        end
        else
        begin
            // spare mode brakes like dynamic brake
            if (mode == tss_pkg::MODE_ACT_BRAKE)
                r.act = 1'b1;
            else
                r.dyn = 1'b1;
            if (sample < tss_pkg::BRAKE_CLEAR_MV)
                open_stamp = '0;
            r.compare = tss_pkg::LEVEL_MAX;
        end
        r.level = level;
        r.rpm = speed;
        return r;
    endfunction

    // Observe beats and register writes at each rising edge
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ref_rpm = tss_pkg::REF_SPEED_RESET;
            arm_mv = tss_pkg::HIGH_THR_RESET;
            pulse_mv = tss_pkg::LOW_THR_RESET;
            coarse_rpm = tss_pkg::COARSE_RESET;
            fine_rpm = tss_pkg::FINE_RESET;
            mode = tss_pkg::MODE_DYN_BRAKE;
            is_armed = 1'b0;
            last_mv = '0;
            closing_edge = 1'b0;
            open_stamp = '0;
            periods = '0;
            speed = '0;
            level = tss_pkg::LEVEL_RESET;
            due_drive_q.delete();
            mismatches = 0;
            pending = 0;
        end
        else
        begin
            // result beat against the oldest prediction
            if (out_valid && out_ready)
            begin
                got = {compare_value, drive_level, speed_rpm, speed_updated,
                       dynamic_brake_pin, active_brake_pin};
                if (due_drive_q.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("%0t: result beat with nothing predicted: cmp %0d lvl %0d",
                                 $time, compare_value, drive_level);
                end
                else
                begin
                    want = due_drive_q.pop_front();
                    if (got !== want)
                    begin
                        mismatches++;
                        if (mismatches <= 10)
                        begin
                            $display("%0t: want cmp %0d lvl %0d rpm %0d upd %0b dyn %0b act %0b",
                                     $time, want.compare, want.level, want.rpm,
                                     want.updated, want.dyn, want.act);
                            $display("%0t:  got cmp %0d lvl %0d rpm %0d upd %0b dyn %0b act %0b",
                                     $time, got.compare, got.level, got.rpm,
                                     got.updated, got.dyn, got.act);
                        end
                    end
                end
            end

            // sample beat in
            if (in_valid && in_ready)
                due_drive_q.push_back(next_drive_result(sample_mv, timestamp_us));

            // register writes
            if (cfg_we)
            begin
                case (cfg_index)
                    tss_pkg::CFG_REF_SPEED: ref_rpm = cfg_wdata;
                    tss_pkg::CFG_HIGH_THR: arm_mv = cfg_wdata[11:0];
                    tss_pkg::CFG_LOW_THR: pulse_mv = cfg_wdata[11:0];
                    tss_pkg::CFG_COARSE: coarse_rpm = cfg_wdata;
                    tss_pkg::CFG_FINE: fine_rpm = cfg_wdata;
                    tss_pkg::CFG_BRAKE: mode = tss_pkg::brake_mode_t'(cfg_wdata[1:0]);
                    default: ;
                endcase
            end
            pending = due_drive_q.size();
        end
    end

endmodule

FILE: sim/tb_top.sv
`timescale 1ns / 100ps

module tb_top;

    localparam int WATCHDOG_LIMIT = 2000;
    localparam int RAND_BEATS = 1920;
    localparam int DRAIN_TAIL = 30;

    typedef enum int {
        STIM_FAST,
        STIM_PULSE,
        STIM_NOISE
    } stim_style_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic in_valid = 1'b0;
    logic in_ready;
    logic [11:0] sample_mv = '0;
    logic [15:0] timestamp_us = '0;
    logic out_valid;
    logic out_ready = 1'b0;
    logic [9:0] compare_value;
    logic [9:0] drive_level;
    logic [15:0] speed_rpm;
    logic speed_updated;
    logic dynamic_brake_pin;
    logic active_brake_pin;
    logic cfg_we = 1'b0;
    logic [2:0] cfg_index = '0;
    logic [13:0] cfg_wdata = '0;

    int mismatches;
    int pending;
    int send_idle_pct = 36;
    int recv_idle_pct = 70;
    int rand_sent = 0;
    int idle_cycles;
    logic [15:0] stamp_now = '0;

    tachometer_speed_stepper_core #(
        .STAMP_BITS(16),
        .UPDATE_INTERVAL(60)
    ) dut (
        .clk(clk),
        .rst_n(rst_n),
        .in_valid(in_valid),
        .in_ready(in_ready),
        .sample_mv(sample_mv),
        .timestamp_us(timestamp_us),
        .out_valid(out_valid),
        .out_ready(out_ready),
        .compare_value(compare_value),
        .drive_level(drive_level),
        .speed_rpm(speed_rpm),
        .speed_updated(speed_updated),
        .dynamic_brake_pin(dynamic_brake_pin),
        .active_brake_pin(active_brake_pin),
        .cfg_we(cfg_we),
        .cfg_index(cfg_index),
        .cfg_wdata(cfg_wdata)
    );

    tss_checker #(
        .STAMP_BITS(16),
        .UPDATE_INTERVAL(60)
    ) u_checker (
        .clk(clk),
        .rst_n(rst_n),
        .in_valid(in_valid),
        .in_ready(in_ready),
        .sample_mv(sample_mv),
        .timestamp_us(timestamp_us),
        .out_valid(out_valid),
        .out_ready(out_ready),
        .compare_value(compare_value),
        .drive_level(drive_level),
        .speed_rpm(speed_rpm),
        .speed_updated(speed_updated),
        .dynamic_brake_pin(dynamic_brake_pin),
        .active_brake_pin(active_brake_pin),
        .cfg_we(cfg_we),
        .cfg_index(cfg_index),
        .cfg_wdata(cfg_wdata),
        .mismatches(mismatches),
        .pending(pending)
    );

    // 10 ns clock
    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Receiver back-pressure
    always @(negedge clk)
        out_ready <= ($urandom_range(99) >= recv_idle_pct);

    // Watchdog on cycles without any beat
    initial
    begin
        idle_cycles = 0;
        while (idle_cycles < WATCHDOG_LIMIT)
        begin
            @(posedge clk);
            if ((in_valid && in_ready) || (out_valid && out_ready))
                idle_cycles = 0;
            else
                idle_cycles++;
        end
        $display("tb_top NOT OK");
        $finish;
    end

    // One sample beat; entered and left at a falling edge
    task automatic send_beat(input logic [11:0] mv, input logic [15:0] stamp);
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid <= 1'b1;
        sample_mv <= mv;
        timestamp_us <= stamp;
        do
            @(posedge clk);
        while (!in_ready);
        @(negedge clk);
    endtask

    // Hold off the sender until every predicted beat has come back
    task automatic drain_results();
        in_valid <= 1'b0;
        do
            @(negedge clk);
        while (pending != 0);
    endtask

    // Write all six registers while the core is idle
    task automatic apply_config(input tss_pkg::brake_mode_t mode, input int ref_rpm,
                                input int hi, input int lo, input int coarse,
                                input int fine);
        drain_results();
        repeat (4) @(negedge clk);
        cfg_we <= 1'b1;
        cfg_index <= tss_pkg::CFG_REF_SPEED;
        cfg_wdata <= 14'(ref_rpm);
        @(negedge clk);
        cfg_index <= tss_pkg::CFG_HIGH_THR;
        cfg_wdata <= 14'(hi);
        @(negedge clk);
        cfg_index <= tss_pkg::CFG_LOW_THR;
        cfg_wdata <= 14'(lo);
        @(negedge clk);
        cfg_index <= tss_pkg::CFG_COARSE;
        cfg_wdata <= 14'(coarse);
        @(negedge clk);
        cfg_index <= tss_pkg::CFG_FINE;
        cfg_wdata <= 14'(fine);
        @(negedge clk);
        cfg_index <= tss_pkg::CFG_BRAKE;
        cfg_wdata <= {12'd0, mode};
        @(negedge clk);
        cfg_we <= 1'b0;
    endtask

    // Random sample, biased toward rails and thresholds
    function automatic logic [11:0] noise_mv(input int hi, input int lo);
        case ($urandom_range(7))
            0: return 12'd0;
            1: return 12'd3300;
            2: return 12'(hi);
            3: return 12'(lo);
            default: return 12'($urandom_range(3300, 0));
        endcase
    endfunction

    // Configure, then send random beats in the given style
    task automatic run_phase(input tss_pkg::brake_mode_t mode, input int ref_rpm,
                             input int hi, input int lo, input int coarse,
                             input int fine, input stim_style_t style, input int beats,
                             input int inc_lo, input int inc_hi);
        int n;
        int seq_pos;
        int roll;
        logic [11:0] mv;
        apply_config(mode, ref_rpm, hi, lo, coarse, fine);
        seq_pos = 0;
        for (n = 0; n < beats; n++)
        begin
            // idling profile follows overall progress
            if (rand_sent < RAND_BEATS / 3)
            begin
                send_idle_pct = 36;
                recv_idle_pct = 70;
            end
            else if (rand_sent < 2 * RAND_BEATS / 3)
            begin
                send_idle_pct = 70;
                recv_idle_pct = 36;
            end
            else
            begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end

            roll = $urandom_range(99);
            case (style)
                STIM_FAST:
                    mv = (roll < 4) ? noise_mv(hi, lo) : 12'($urandom_range(lo - 1, hi + 1));
                STIM_PULSE:
                begin
                    // arm, low, low makes one pulse; noise breaks some sequences
                    if (roll < 8)
                        mv = noise_mv(hi, lo);
                    else if (seq_pos == 0)
                    begin
                        mv = (hi < 3300) ? 12'($urandom_range(3300, hi + 1)) : 12'd3300;
                        seq_pos = 1;
                    end
                    else
                    begin
                        mv = (lo > 0) ? 12'($urandom_range(lo - 1, 0)) : 12'd0;
                        seq_pos = (seq_pos == 2) ? 0 : seq_pos + 1;
                    end
                end
                default: mv = noise_mv(hi, lo);
            endcase

            roll = $urandom_range(99);
            if (roll < 94)
                stamp_now = stamp_now + 16'($urandom_range(inc_hi, inc_lo));
            else if (roll >= 97)
                stamp_now = 16'($urandom_range(65535, 0));
            send_beat(mv, stamp_now);
            rand_sent++;
            if ($urandom_range(249) == 0)
                drain_results();
        end
    endtask

    // Stimulus and verdict
    initial
    begin
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // dynamic brake out of reset, low samples clear the start stamp
        send_beat(12'd0, 16'd0);
        send_beat(12'd3300, 16'd65535);
        send_beat(12'd4, 16'd1);
        send_beat(12'd5, 16'd2);

        // run: period across the timer wrap, then a zero-length period
        apply_config(tss_pkg::MODE_RUN, 400, 2800, 100, 260, 40);
        send_beat(12'd2801, 16'd100);
        send_beat(12'd50, 16'd200);
        send_beat(12'd0, 16'd65535);
        send_beat(12'd3300, 16'd0);
        send_beat(12'd99, 16'd0);
        send_beat(12'd99, 16'd10);
        send_beat(12'd2800, 16'd20);
        send_beat(12'd3000, 16'd30);
        send_beat(12'd0, 16'd40);
        send_beat(12'd0, 16'd5000);
        send_beat(12'd3000, 16'd5000);
        send_beat(12'd0, 16'd5000);
        send_beat(12'd0, 16'd5000);

        // crossed thresholds: each sample arms and pulses
        apply_config(tss_pkg::MODE_RUN, 400, 0, 3300, 260, 40);
        send_beat(12'd1, 16'd7000);
        send_beat(12'd3299, 16'd9000);
        send_beat(12'd2, 16'd9001);

        // spare brake mode
        apply_config(tss_pkg::MODE_SPARE, 400, 2800, 100, 260, 40);
        send_beat(12'd0, 16'd11);
        send_beat(12'd3300, 16'd12);

        // random phases
        run_phase(tss_pkg::MODE_RUN, 0, 0, 3300, 0, 0, STIM_FAST, 1100, 500, 3000);
        run_phase(tss_pkg::MODE_RUN, 400, 2800, 100, 260, 40, STIM_PULSE, 250, 8000, 15000);
        run_phase(tss_pkg::MODE_RUN, 9999, 3300, 0, 9999, 0, STIM_NOISE, 60, 0, 65535);
        run_phase(tss_pkg::MODE_ACT_BRAKE, 400, 2800, 100, 260, 40, STIM_NOISE, 100, 0, 4000);
        run_phase(tss_pkg::MODE_RUN, 600, 1500, 800, 9999, 9999, STIM_PULSE, 200, 0, 20000);
        run_phase(tss_pkg::MODE_DYN_BRAKE, 5000, 3300, 3300, 0, 9999, STIM_NOISE, 60, 0, 4000);
        run_phase(tss_pkg::MODE_RUN, 9999, 2000, 300, 100, 50, STIM_PULSE, 150, 0, 50);

        drain_results();
        repeat (DRAIN_TAIL) @(negedge clk);
        if (mismatches == 0 && pending == 0)
            $display("tb_top OK");
        else
            $display("tb_top NOT OK");
        $finish;
    end

endmodule
